// File: design/tmvp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tmvp_pkg;

    // field widths of the stream items
    localparam int ACT_W     = 8;
    localparam int SLOT_W    = 6;
    localparam int SCALE_W   = 32;
    localparam int WEIGHT_W  = 8;
    localparam int SUM_W     = 24;
    localparam int PROD_W    = 55;
    localparam int ROW_W     = 15;
    localparam int GROUP_W   = 6;
    localparam int LANES     = 4;

    // hard limits that hold whatever the module parameters say
    localparam int ROWS_CAP   = 32768;
    localparam int GROUPS_CAP = 64;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 104;
    localparam int OUT_PAD_W  = OUT_DATA_W - PROD_W - SUM_W - GROUP_W - ROW_W;

    // input beat layout, lowest bit up
    localparam int IN_SLOT_LO   = 0;
    localparam int IN_SCALE_LO  = IN_SLOT_LO + SLOT_W;
    localparam int IN_WEIGHT_LO = IN_SCALE_LO + SCALE_W;
    localparam int IN_ACT_LO    = IN_WEIGHT_LO + WEIGHT_W;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int LEN_W      = 16;
    localparam int NGROUPS_W  = 7;

    localparam logic [LEN_W-1:0]     RST_ROW_LENGTH     = 16'd3072;
    localparam logic [LEN_W-1:0]     RST_ROW_TOTAL      = 16'd3072;
    localparam logic [LEN_W-1:0]     RST_ROWS_PER_GROUP = 16'd32768;
    localparam logic [NGROUPS_W-1:0] RST_GROUPS_IN_USE  = 7'd1;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_DATA  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        REG_ROW_LENGTH     = 2'd0,
        REG_ROW_TOTAL      = 2'd1,
        REG_ROWS_PER_GROUP = 2'd2,
        REG_GROUPS_IN_USE  = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        CODE_ZERO = 2'd0,
        CODE_PLUS = 2'd1,
        CODE_MINUS = 2'd2,
        CODE_ZERO_ALT = 2'd3
    } t_code;

    typedef struct packed {
        logic [ROW_W-1:0]        row_number;
        logic [GROUP_W-1:0]      group_number;
        logic signed [SUM_W-1:0] dot_sum;
    } t_row_info;

endpackage

`default_nettype wire

// File: design/tmvp_scale_out.sv
`timescale 1ns / 1ps
`default_nettype none

module tmvp_scale_out (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire tmvp_pkg::t_row_info                  i_info,
    input  wire logic signed [tmvp_pkg::SCALE_W-1:0]  i_scale,
    output logic                                      o_tvalid,
    input  wire logic                                 i_tready,
    // row_number, group_number, dot_sum, scaled_sum, zero pad
    output logic [tmvp_pkg::OUT_DATA_W-1:0]           o_tdata
);

    localparam int FULL_W = tmvp_pkg::SUM_W + tmvp_pkg::SCALE_W;

    logic signed [FULL_W-1:0]            w_prod;
    logic signed [tmvp_pkg::PROD_W-1:0]  w_scaled;
    logic                                r_valid;
    tmvp_pkg::t_row_info                 r_info;
    logic signed [tmvp_pkg::PROD_W-1:0]  r_scaled;

    assign w_prod = $signed(i_info.dot_sum) * $signed(i_scale);

    // clip the full product into the result width
    always_comb begin
        if (w_prod[FULL_W-1] != w_prod[tmvp_pkg::PROD_W-1]) begin
            if (w_prod[FULL_W-1]) begin
                w_scaled = {1'b1, {(tmvp_pkg::PROD_W-1){1'b0}}};
            end else begin
                w_scaled = {1'b0, {(tmvp_pkg::PROD_W-1){1'b1}}};
            end
        end else begin
            w_scaled = w_prod[tmvp_pkg::PROD_W-1:0];
        end
    end

    assign o_ready = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_info   <= i_info;
            r_scaled <= w_scaled;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = {{tmvp_pkg::OUT_PAD_W{1'b0}}, r_scaled, r_info.dot_sum,
                       r_info.group_number, r_info.row_number};

endmodule

`default_nettype wire

// File: design/ternary_matrix_vector_product.sv
`timescale 1ns / 1ps
`default_nettype none

// Streams packed ternary weights against int8 activations, four per beat, and takes one
// beat every clock unless a stalled output backs up the pipeline. A beat passes an input
// register, then the accumulate stage, where the row, group and column counters and the
// running sum move on and the group scale is read from the 64-entry table, then the
// multiply stage that forms the scaled sum into the output register. Beats that end no
// row (start, scale load, mid-row data) leave no result and close up behind a stalled
// output, so the input keeps taking beats until all three stages hold one. The scale
// table has no reset: load every group in use before its rows arrive.
module ternary_matrix_vector_product #(
    parameter int MAX_ROW_LENGTH = 32768,
    parameter int MAX_ROWS       = 32768,
    parameter int MAX_GROUPS     = 64
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // slave stream
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // scale_slot, scale_value, weight_byte, act_first, act_second, act_third,
    // act_fourth, zero pad
    input  wire logic [tmvp_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // action
    input  wire logic [1:0]                           s_axis_tuser,
    // master stream
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // row_number, group_number, dot_sum, scaled_sum, zero pad
    output logic [tmvp_pkg::OUT_DATA_W-1:0]           m_axis_tdata,
    // register port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [tmvp_pkg::CFG_ADDR_W-1:0]      paddr,
    input  wire logic [tmvp_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [tmvp_pkg::CFG_DATA_W-1:0]           prdata,
    output logic                                      pready
);

    localparam int COL_W       = $clog2(MAX_ROW_LENGTH + 4);
    localparam int ROW_LIMIT   = (MAX_ROWS < tmvp_pkg::ROWS_CAP) ? MAX_ROWS
                                                                 : tmvp_pkg::ROWS_CAP;
    localparam int ROW_CNT_W   = (ROW_LIMIT > 1) ? $clog2(ROW_LIMIT) : 1;
    localparam int GROUP_LIMIT = (MAX_GROUPS < tmvp_pkg::GROUPS_CAP) ? MAX_GROUPS
                                                                     : tmvp_pkg::GROUPS_CAP;
    localparam int TBL_AW      = (GROUP_LIMIT > 1) ? $clog2(GROUP_LIMIT) : 1;
    localparam int LW          = tmvp_pkg::LEN_W;
    localparam int GW          = tmvp_pkg::GROUP_W;
    localparam int NW          = tmvp_pkg::NGROUPS_W;
    localparam int SW          = tmvp_pkg::SUM_W;
    localparam int AW          = tmvp_pkg::ACT_W;

    // configuration
    logic [LW-1:0] r_row_length;
    logic [LW-1:0] r_row_total;
    logic [LW-1:0] r_rows_per_group;
    logic [NW-1:0] r_groups_in_use;
    logic          w_cfg_write;

    logic [COL_W-1:0] w_len;
    logic [LW-1:0]    w_total;
    logic [LW-1:0]    w_per_group;
    logic [NW-1:0]    w_ngroups;

    // input register
    logic                                 r_v1;
    tmvp_pkg::t_action                    r_action;
    logic [tmvp_pkg::SLOT_W-1:0]          r_slot;
    logic signed [tmvp_pkg::SCALE_W-1:0]  r_scale_value;
    logic [tmvp_pkg::WEIGHT_W-1:0]        r_weight;
    logic signed [AW-1:0]                 r_acts [tmvp_pkg::LANES];

    // running state
    logic [COL_W-1:0]     r_col, n_col;
    logic [ROW_CNT_W-1:0] r_row, n_row;
    logic [LW-1:0]        r_rig, n_rig;
    logic [GW-1:0]        r_grp, n_grp;
    logic signed [SW-1:0] r_sum, n_sum;

    logic signed [tmvp_pkg::SCALE_W-1:0] r_table [GROUP_LIMIT];

    // accumulate stage output
    logic                                 r_v2;
    tmvp_pkg::t_row_info                  r_info2;
    logic signed [tmvp_pkg::SCALE_W-1:0]  r_scale2;

    logic                 w_en2;
    logic                 w_en3;
    logic                 w_move1;
    logic                 w_row_end;
    logic [COL_W-1:0]     w_col_next;
    logic signed [SW-1:0] w_sum;
    logic                 w_emit;

    // ------------------------------------------------------------------ registers
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length     <= tmvp_pkg::RST_ROW_LENGTH;
            r_row_total      <= tmvp_pkg::RST_ROW_TOTAL;
            r_rows_per_group <= tmvp_pkg::RST_ROWS_PER_GROUP;
            r_groups_in_use  <= tmvp_pkg::RST_GROUPS_IN_USE;
        end else if (w_cfg_write) begin
            unique case (tmvp_pkg::t_reg_idx'(paddr[3:2]))
                tmvp_pkg::REG_ROW_LENGTH:     r_row_length     <= pwdata[LW-1:0];
                tmvp_pkg::REG_ROW_TOTAL:      r_row_total      <= pwdata[LW-1:0];
                tmvp_pkg::REG_ROWS_PER_GROUP: r_rows_per_group <= pwdata[LW-1:0];
                tmvp_pkg::REG_GROUPS_IN_USE:  r_groups_in_use  <= pwdata[NW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (tmvp_pkg::t_reg_idx'(paddr[3:2]))
            tmvp_pkg::REG_ROW_LENGTH:     prdata = 32'(r_row_length);
            tmvp_pkg::REG_ROW_TOTAL:      prdata = 32'(r_row_total);
            tmvp_pkg::REG_ROWS_PER_GROUP: prdata = 32'(r_rows_per_group);
            tmvp_pkg::REG_GROUPS_IN_USE:  prdata = 32'(r_groups_in_use);
            default:                      prdata = '0;
        endcase
    end

    // zero reads as one; large row length, row total and group count values clip to what the counters support
    always_comb begin
        if (r_row_length == '0) begin
            w_len = COL_W'(1);
        end else if (32'(r_row_length) > MAX_ROW_LENGTH) begin
            w_len = COL_W'(MAX_ROW_LENGTH);
        end else begin
            w_len = COL_W'(r_row_length);
        end

        if (r_row_total == '0) begin
            w_total = LW'(1);
        end else if (32'(r_row_total) > ROW_LIMIT) begin
            w_total = LW'(ROW_LIMIT);
        end else begin
            w_total = r_row_total;
        end

        if (r_rows_per_group == '0) begin
            w_per_group = LW'(1);
        end else begin
            w_per_group = r_rows_per_group;
        end

        if (r_groups_in_use == '0) begin
            w_ngroups = NW'(1);
        end else if (32'(r_groups_in_use) > GROUP_LIMIT) begin
            w_ngroups = NW'(GROUP_LIMIT);
        end else begin
            w_ngroups = r_groups_in_use;
        end
    end

    // ------------------------------------------------------------------ handshake
    assign w_en2         = !r_v2 || w_en3;
    assign w_move1       = r_v1 && w_en2;
    assign s_axis_tready = !r_v1 || w_en2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (s_axis_tready) begin
            r_v1 <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_action      <= tmvp_pkg::t_action'(s_axis_tuser);
            r_slot        <= s_axis_tdata[tmvp_pkg::IN_SLOT_LO +: tmvp_pkg::SLOT_W];
            r_scale_value <= s_axis_tdata[tmvp_pkg::IN_SCALE_LO +: tmvp_pkg::SCALE_W];
            r_weight      <= s_axis_tdata[tmvp_pkg::IN_WEIGHT_LO +: tmvp_pkg::WEIGHT_W];
            for (int k = 0; k < tmvp_pkg::LANES; k++) begin
                r_acts[k] <= s_axis_tdata[tmvp_pkg::IN_ACT_LO + k*AW +: AW];
            end
        end
    end

    // ------------------------------------------------------------------ accumulate
    // four clipped adds in lane order, lanes past the row end add nothing
    always_comb begin
        logic signed [SW:0]   t;
        logic signed [SW:0]   a;
        logic [COL_W-1:0]     pos;
        w_sum = r_sum;
        for (int k = 0; k < tmvp_pkg::LANES; k++) begin
            pos = r_col + COL_W'(k);
            a   = {{(SW+1-AW){r_acts[k][AW-1]}}, r_acts[k]};
            t   = {w_sum[SW-1], w_sum};
            if (pos < w_len) begin
                case (tmvp_pkg::t_code'(r_weight[2*k +: 2]))
                    tmvp_pkg::CODE_PLUS:  t = t + a;
                    tmvp_pkg::CODE_MINUS: t = t - a;
                    default: ;
                endcase
            end
            if (t[SW] != t[SW-1]) begin
                w_sum = t[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
            end else begin
                w_sum = t[SW-1:0];
            end
        end
    end

    assign w_col_next = r_col + COL_W'(tmvp_pkg::LANES);
    assign w_row_end  = (w_col_next >= w_len);
    assign w_emit     = w_move1 && (r_action == tmvp_pkg::ACT_DATA) && w_row_end;

    always_comb begin
        logic [LW-1:0] rig_inc;
        logic [NW-1:0] grp_tmp;
        n_col   = r_col;
        n_row   = r_row;
        n_rig   = r_rig;
        n_grp   = r_grp;
        n_sum   = r_sum;
        rig_inc = r_rig + LW'(1);
        grp_tmp = {1'b0, r_grp};
        if (w_move1) begin
            case (r_action)
                tmvp_pkg::ACT_START: begin
                    n_col = '0;
                    n_row = '0;
                    n_rig = '0;
                    n_grp = '0;
                    n_sum = '0;
                end
                tmvp_pkg::ACT_DATA: begin
                    if (!w_row_end) begin
                        n_col = w_col_next;
                        n_sum = w_sum;
                    end else begin
                        n_col = '0;
                        n_sum = '0;
                        if (rig_inc >= w_per_group) begin
                            rig_inc = '0;
                            if (grp_tmp + NW'(1) < w_ngroups) begin
                                grp_tmp = grp_tmp + NW'(1);
                            end
                        end
                        // groups_in_use may have shrunk under the current group
                        if (grp_tmp >= w_ngroups) begin
                            grp_tmp = w_ngroups - NW'(1);
                        end
                        n_rig = rig_inc;
                        n_grp = grp_tmp[GW-1:0];
                        if (17'(r_row) + 17'd1 >= 17'(w_total)) begin
                            n_row = '0;
                            n_rig = '0;
                            n_grp = '0;
                        end else begin
                            n_row = r_row + ROW_CNT_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_rig <= '0;
            r_grp <= '0;
            r_sum <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_rig <= n_rig;
            r_grp <= n_grp;
            r_sum <= n_sum;
        end
    end

    // scale table: written by load beats, read for the row being closed
    always_ff @(posedge i_clk) begin
        if (w_move1 && (r_action == tmvp_pkg::ACT_LOAD) && (32'(r_slot) < GROUP_LIMIT)) begin
            r_table[r_slot[TBL_AW-1:0]] <= r_scale_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_scale2 <= r_table[r_grp[TBL_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en2) begin
            r_v2 <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_info2.row_number   <= tmvp_pkg::ROW_W'(r_row);
            r_info2.group_number <= r_grp;
            r_info2.dot_sum      <= w_sum;
        end
    end

    // ------------------------------------------------------------------ multiply
    tmvp_scale_out u_scale_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_v2),
        .o_ready  (w_en3),
        .i_info   (r_info2),
        .i_scale  (r_scale2),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

// File: verif/tmvp_checker.sv
`timescale 1ns / 1ps

module tmvp_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    input  wire logic                              i_s_tready,
    // scale_slot, scale_value, weight_byte, act_first .. act_fourth, zero pad
    input  wire logic [tmvp_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // action
    input  wire logic [1:0]                        i_s_tuser,
    input  wire logic                              i_m_tvalid,
    input  wire logic                              i_m_tready,
    // row_number, group_number, dot_sum, scaled_sum, zero pad
    input  wire logic [tmvp_pkg::OUT_DATA_W-1:0]   i_m_tdata,
    input  wire logic                              i_psel,
    input  wire logic                              i_penable,
    input  wire logic                              i_pwrite,
    input  wire logic [tmvp_pkg::CFG_ADDR_W-1:0]   i_paddr,
    input  wire logic [tmvp_pkg::CFG_DATA_W-1:0]   i_pwdata,
    input  wire logic [tmvp_pkg::CFG_DATA_W-1:0]   i_prdata,
    input  wire logic                              i_pready,
    output int                                     o_fail_count,
    output int                                     o_rows_due,
    output int                                     o_rows_checked
);
    import tmvp_pkg::*;

    localparam int unsigned LEN_CAP = 32768;
    localparam longint SUM_HI  = (64'sd1 <<< (SUM_W - 1)) - 1;
    localparam longint SUM_LO  = -(64'sd1 <<< (SUM_W - 1));
    localparam longint PROD_HI = (64'sd1 <<< (PROD_W - 1)) - 1;
    localparam longint PROD_LO = -(64'sd1 <<< (PROD_W - 1));

    typedef struct packed {
        logic [ROW_W-1:0]         row_number;
        logic [GROUP_W-1:0]       group_number;
        logic signed [SUM_W-1:0]  dot_sum;
        logic signed [PROD_W-1:0] scaled_sum;
    } row_result_t;

    logic [LEN_W-1:0]          row_length;
    logic [LEN_W-1:0]          row_total;
    logic [LEN_W-1:0]          rows_per_group;
    logic [NGROUPS_W-1:0]      groups_in_use;

    logic signed [SCALE_W-1:0] scales [GROUPS_CAP];
    int unsigned               col_pos;
    int unsigned               row_idx;
    int unsigned               group_run;
    int unsigned               grp_sel;
    longint                    acc_sum;

    row_result_t               rows_due [$];
    row_result_t               want;
    row_result_t               got;
    t_reg_idx                  reg_sel;
    logic [CFG_DATA_W-1:0]     reg_want;

    task automatic wipe_counters();
        col_pos   = 0;
        row_idx   = 0;
        group_run = 0;
        grp_sel   = 0;
        acc_sum   = 0;
    endtask

    task automatic accumulate_beat(input logic [1:0] action, input logic [IN_DATA_W-1:0] data);
        int unsigned len_eff;
        int unsigned total_eff;
        int unsigned per_eff;
        int unsigned ngrp_eff;
        longint acc;
        longint prod;
        logic signed [ACT_W-1:0] act;
        row_result_t res;
        case (t_action'(action))
            ACT_START: wipe_counters();
            ACT_LOAD: scales[data[IN_SLOT_LO +: SLOT_W]] = data[IN_SCALE_LO +: SCALE_W];
            ACT_DATA: begin
                len_eff   = (row_length == 0) ? 1 :
                            ((32'(row_length) > LEN_CAP) ? LEN_CAP : 32'(row_length));
                total_eff = (row_total == 0) ? 1 :
                            ((32'(row_total) > ROWS_CAP) ? ROWS_CAP : 32'(row_total));
                per_eff   = (rows_per_group == 0) ? 1 : 32'(rows_per_group);
                ngrp_eff  = (groups_in_use == 0) ? 1 :
                            ((32'(groups_in_use) > GROUPS_CAP) ? GROUPS_CAP
                                                               : 32'(groups_in_use));
                acc = acc_sum;
                for (int k = 0; k < LANES; k++) begin
                    if (col_pos + k < len_eff) begin
                        act = data[IN_ACT_LO + ACT_W * k +: ACT_W];
                        case (t_code'(data[IN_WEIGHT_LO + 2 * k +: 2]))
                            CODE_PLUS:  acc += longint'(act);
                            CODE_MINUS: acc -= longint'(act);
                            default: ;
                        endcase
                        if (acc > SUM_HI) acc = SUM_HI;
                        if (acc < SUM_LO) acc = SUM_LO;
                    end
                end
                acc_sum = acc;
                col_pos += LANES;
                if (col_pos >= len_eff) begin
                    prod = acc * longint'(scales[grp_sel[GROUP_W-1:0]]);
                    if (prod > PROD_HI) prod = PROD_HI;
                    if (prod < PROD_LO) prod = PROD_LO;
                    res.row_number   = row_idx[ROW_W-1:0];
                    res.group_number = grp_sel[GROUP_W-1:0];
                    res.dot_sum      = acc[SUM_W-1:0];
                    res.scaled_sum   = prod[PROD_W-1:0];
                    rows_due.push_back(res);
                    col_pos = 0;
                    acc_sum = 0;
                    group_run++;
                    if (group_run >= per_eff) begin
                        group_run = 0;
                        if (grp_sel + 1 < ngrp_eff) grp_sel++;
                    end
                    if (grp_sel >= ngrp_eff) grp_sel = ngrp_eff - 1;
                    row_idx++;
                    // matrix wrap resets the row and group tracking
                    if (row_idx >= total_eff) begin
                        row_idx   = 0;
                        group_run = 0;
                        grp_sel   = 0;
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            row_length     = RST_ROW_LENGTH;
            row_total      = RST_ROW_TOTAL;
            rows_per_group = RST_ROWS_PER_GROUP;
            groups_in_use  = RST_GROUPS_IN_USE;
            wipe_counters();
            rows_due.delete();
            o_fail_count   = 0;
            o_rows_checked = 0;
        end else begin
            if (i_psel && i_penable && i_pready) begin
                reg_sel = t_reg_idx'(i_paddr[3:2]);
                if (i_pwrite) begin
                    case (reg_sel)
                        REG_ROW_LENGTH:     row_length     = i_pwdata[LEN_W-1:0];
                        REG_ROW_TOTAL:      row_total      = i_pwdata[LEN_W-1:0];
                        REG_ROWS_PER_GROUP: rows_per_group = i_pwdata[LEN_W-1:0];
                        REG_GROUPS_IN_USE:  groups_in_use  = i_pwdata[NGROUPS_W-1:0];
                        default: ;
                    endcase
                end else begin
                    reg_want = '0;
                    case (reg_sel)
                        REG_ROW_LENGTH:     reg_want[LEN_W-1:0]     = row_length;
                        REG_ROW_TOTAL:      reg_want[LEN_W-1:0]     = row_total;
                        REG_ROWS_PER_GROUP: reg_want[LEN_W-1:0]     = rows_per_group;
                        REG_GROUPS_IN_USE:  reg_want[NGROUPS_W-1:0] = groups_in_use;
                        default: ;
                    endcase
                    if (i_prdata !== reg_want) begin
                        $error("%s: expected %0d, got %0d", reg_sel.name(), reg_want, i_prdata);
                        o_fail_count++;
                    end
                end
            end

            if (i_s_tvalid && i_s_tready) accumulate_beat(i_s_tuser, i_s_tdata);

            if (i_m_tvalid && i_m_tready) begin
                got.row_number   = i_m_tdata[0 +: ROW_W];
                got.group_number = i_m_tdata[ROW_W +: GROUP_W];
                got.dot_sum      = i_m_tdata[ROW_W + GROUP_W +: SUM_W];
                got.scaled_sum   = i_m_tdata[ROW_W + GROUP_W + SUM_W +: PROD_W];
                if (rows_due.size() == 0) begin
                    $error("row result beat with no row outstanding: row_number %0d, dot_sum %0d",
                           got.row_number, got.dot_sum);
                    o_fail_count++;
                end else begin
                    want = rows_due.pop_front();
                    o_rows_checked++;
                    if (got.row_number !== want.row_number) begin
                        $error("row_number: expected %0d, got %0d",
                               want.row_number, got.row_number);
                        o_fail_count++;
                    end
                    if (got.group_number !== want.group_number) begin
                        $error("group_number: expected %0d, got %0d",
                               want.group_number, got.group_number);
                        o_fail_count++;
                    end
                    if (got.dot_sum !== want.dot_sum) begin
                        $error("dot_sum: expected %0d, got %0d", want.dot_sum, got.dot_sum);
                        o_fail_count++;
                    end
                    if (got.scaled_sum !== want.scaled_sum) begin
                        $error("scaled_sum: expected %0d, got %0d",
                               want.scaled_sum, got.scaled_sum);
                        o_fail_count++;
                    end
                end
            end
        end
        o_rows_due = rows_due.size();
    end

endmodule

// File: verif/tb_ternary_matrix_vector_product.sv
`timescale 1ns / 1ps

module tb_ternary_matrix_vector_product;
    import tmvp_pkg::*;

    localparam logic [1:0] ACT_UNUSED     = 2'd3;
    localparam int CYCLE_LIMIT       = 2_000_000;
    localparam int HOLD_CYCLES       = 400;
    localparam int SETTLE_CYCLES     = 8;
    localparam int RANDOM_SETTINGS   = 8;
    localparam int ITEMS_PER_SETTING = 100;
    localparam int RESET_ROW_BEATS   = 16;
    localparam int LONG_ROW_BEATS    = 96;
    localparam int WRAP_ROWS         = 150;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata;
    logic [1:0]              s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [CFG_ADDR_W-1:0]   paddr;
    logic [CFG_DATA_W-1:0]   pwdata;
    logic [CFG_DATA_W-1:0]   prdata;
    logic                    pready;

    int   fail_count;
    int   rows_due;
    int   rows_checked;
    int   cycle_count;
    int   beats_sent;
    int   settings_used;
    int   counted;
    logic tx_idle;
    logic rx_idle;
    logic hold_out;
    logic hold_done;
    logic item_counts;

    logic [LEN_W-1:0]     cfg_len;
    logic [LEN_W-1:0]     cfg_total;
    logic [LEN_W-1:0]     cfg_per_group;
    logic [NGROUPS_W-1:0] cfg_groups;

    ternary_matrix_vector_product DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    tmvp_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (s_axis_tvalid),
        .i_s_tready     (s_axis_tready),
        .i_s_tdata      (s_axis_tdata),
        .i_s_tuser      (s_axis_tuser),
        .i_m_tvalid     (m_axis_tvalid),
        .i_m_tready     (m_axis_tready),
        .i_m_tdata      (m_axis_tdata),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_prdata       (prdata),
        .i_pready       (pready),
        .o_fail_count   (fail_count),
        .o_rows_due     (rows_due),
        .o_rows_checked (rows_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // result side: random back-pressure, plus one long hold when asked
    initial begin
        m_axis_tready = 1'b0;
        hold_done     = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_out && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end else if (rx_idle && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 8)) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic push_beat(input logic [1:0] action, input logic [SLOT_W-1:0] slot,
                             input logic [SCALE_W-1:0] scale, input logic [WEIGHT_W-1:0] weight,
                             input logic [4*ACT_W-1:0] acts);
        int gap;
        @(negedge i_clk);
        if (tx_idle && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 9);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= action;
        s_axis_tdata  <= {2'b00, acts, weight, scale, slot};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic apb_access(input logic write, input t_reg_idx idx,
                              input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_regs();
        for (int i = 0; i < 4; i++) apb_access(1'b0, t_reg_idx'(i), '0);
    endtask

    // wait for every row result, then for beats still in the pipeline
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (rows_due != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_matrix(input logic [LEN_W-1:0] len, input logic [LEN_W-1:0] total,
                              input logic [LEN_W-1:0] per_group,
                              input logic [NGROUPS_W-1:0] ngroups);
        drain();
        apb_access(1'b1, REG_ROW_LENGTH, CFG_DATA_W'(len));
        apb_access(1'b1, REG_ROW_TOTAL, CFG_DATA_W'(total));
        apb_access(1'b1, REG_ROWS_PER_GROUP, CFG_DATA_W'(per_group));
        apb_access(1'b1, REG_GROUPS_IN_USE, CFG_DATA_W'(ngroups));
        read_regs();
        settings_used++;
    endtask

    function automatic logic [4*ACT_W-1:0] rand_acts();
        logic [4*ACT_W-1:0] v;
        v = $urandom;
        for (int k = 0; k < LANES; k++) begin
            case ($urandom_range(0, 7))
                0: v[ACT_W * k +: ACT_W] = 8'h80;
                1: v[ACT_W * k +: ACT_W] = 8'h7F;
                default: ;
            endcase
        end
        return v;
    endfunction

    task automatic data_beat(input logic [WEIGHT_W-1:0] weight, input logic [4*ACT_W-1:0] acts);
        push_beat(ACT_DATA, SLOT_W'($urandom), $urandom, weight, acts);
    endtask

    // mostly data beats, with some starts, table loads and the unused code
    task automatic random_item(output logic counts);
        int pick;
        logic [SCALE_W-1:0] scale;
        pick  = $urandom_range(0, 99);
        counts = 1'b1;
        case ($urandom_range(0, 5))
            0: scale = 32'h8000_0000;
            1: scale = 32'h7FFF_FFFF;
            default: scale = $urandom;
        endcase
        if (pick < 3) begin
            push_beat(ACT_START, SLOT_W'($urandom), $urandom, WEIGHT_W'($urandom), $urandom);
        end else if (pick < 8) begin
            push_beat(ACT_LOAD, SLOT_W'($urandom), scale, WEIGHT_W'($urandom), $urandom);
        end else if (pick < 11) begin
            push_beat(ACT_UNUSED, SLOT_W'($urandom), $urandom, WEIGHT_W'($urandom), $urandom);
            counts = 1'b0;
        end else begin
            data_beat(WEIGHT_W'($urandom), rand_acts());
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_START;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        hold_out      = 1'b0;
        tx_idle       = 1'b1;
        rx_idle       = 1'b1;
        beats_sent    = 0;
        settings_used = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        read_regs();
        // the table has no reset, so fill every slot before any row reads one
        for (int s = 0; s < GROUPS_CAP; s++) begin
            push_beat(ACT_LOAD, s[SLOT_W-1:0],
                      (s == 0) ? 32'h0100_0000 : (s == GROUPS_CAP - 1) ? 32'h8000_0000 : $urandom,
                      WEIGHT_W'($urandom), $urandom);
        end
        // part of a row at the reset register values
        repeat (RESET_ROW_BEATS) data_beat(WEIGHT_W'($urandom), rand_acts());

        // directed: six-wide rows, so the second beat of each row is half used
        set_matrix(16'd6, 16'd3, 16'd1, 7'd2);
        push_beat(ACT_START, SLOT_W'($urandom), $urandom, WEIGHT_W'($urandom), $urandom);
        data_beat(8'h55, 32'h7F7F_7F7F);
        push_beat(ACT_UNUSED, SLOT_W'($urandom), $urandom, WEIGHT_W'($urandom), $urandom);
        push_beat(ACT_LOAD, 6'd1, 32'h7FFF_FFFF, WEIGHT_W'($urandom), $urandom);
        data_beat(8'hAA, 32'h8080_8080);
        data_beat(8'hFF, 32'h7F80_7F80);
        data_beat(8'h00, 32'h8080_7F7F);
        data_beat(8'h99, 32'h807F_807F);
        // start in the middle of a row drops the partial sum
        push_beat(ACT_START, SLOT_W'($urandom), $urandom, WEIGHT_W'($urandom), $urandom);
        data_beat(8'h66, rand_acts());
        data_beat(WEIGHT_W'($urandom), rand_acts());
        push_beat(ACT_LOAD, 6'd0, 32'h8000_0000, WEIGHT_W'($urandom), $urandom);
        repeat (6) data_beat(WEIGHT_W'($urandom), rand_acts());
        data_beat(8'hAA, 32'h8080_8080);
        // shorter row length with a row half done: next beat only closes it
        set_matrix(16'd2, 16'd3, 16'd1, 7'd2);
        data_beat(8'h55, 32'h7F7F_7F7F);

        // zero and oversized register values
        set_matrix(16'd0, 16'd0, 16'd0, 7'd0);
        repeat (3) data_beat(WEIGHT_W'($urandom), rand_acts());
        set_matrix(16'd3, 16'h9000, 16'hFFFF, 7'd100);
        repeat (4) data_beat(WEIGHT_W'($urandom), rand_acts());

        // long hold on the result side while beats keep coming
        set_matrix(16'd4, 16'd100, 16'd1, 7'd64);
        @(posedge i_clk);
        hold_out = 1'b1;
        repeat (110) data_beat(WEIGHT_W'($urandom), rand_acts());

        for (int r = 0; r < RANDOM_SETTINGS; r++) begin
            cfg_len = ($urandom_range(0, 9) == 0) ? 16'd0 :
                      ($urandom_range(0, 4) == 0) ? 16'($urandom_range(17, 64)) :
                      16'($urandom_range(1, 16));
            cfg_total     = 16'($urandom_range(0, 24));
            cfg_per_group = 16'($urandom_range(0, 6));
            cfg_groups    = ($urandom_range(0, 5) == 0) ? 7'd100 : 7'($urandom_range(0, 9));
            set_matrix(cfg_len, cfg_total, cfg_per_group, cfg_groups);
            tx_idle = (r % 4 == 0) || (r % 4 == 1);
            rx_idle = (r % 4 == 0) || (r % 4 == 2);
            counted = 0;
            while (counted < ITEMS_PER_SETTING) begin
                random_item(item_counts);
                if (item_counts) counted++;
            end
        end

        // closing part runs flat out: long rows at extreme activations and scales
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        set_matrix(16'd128, 16'd2, 16'd1, 7'd2);
        push_beat(ACT_LOAD, 6'd0, 32'h7FFF_FFFF, WEIGHT_W'($urandom), $urandom);
        push_beat(ACT_LOAD, 6'd1, 32'h8000_0000, WEIGHT_W'($urandom), $urandom);
        push_beat(ACT_START, SLOT_W'($urandom), $urandom, WEIGHT_W'($urandom), $urandom);
        repeat (LONG_ROW_BEATS) data_beat(8'hAA, 32'h8080_8080);
        set_matrix(16'd130, 16'd2, 16'd1, 7'd2);
        repeat (LONG_ROW_BEATS) data_beat(8'h55, 32'h8080_8080);

        // one-beat rows past the last group and through the row wrap
        set_matrix(16'd1, 16'd70, 16'd1, 7'd127);
        push_beat(ACT_START, SLOT_W'($urandom), $urandom, WEIGHT_W'($urandom), $urandom);
        repeat (WRAP_ROWS) data_beat(WEIGHT_W'($urandom), rand_acts());

        drain();
        $display("summary: %0d beats taken, %0d row results checked, %0d register settings",
                 beats_sent, rows_checked, settings_used);
        $display("summary: all action codes, register clamps, group clamp, row wrap, long stall");
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
